// ===== rtl/pu_pkg.sv =====
package pu_pkg;

	// Store capacity used when the top level is not overridden.
	localparam int MAX_SAMPLES_DEF = 64;

	// Field widths.
	localparam int PHASE_W = 16;
	localparam int TOL_W   = 15;
	localparam int OUT_W   = 23;

	// 2pi in Q2.13 radians, and the reset value of the jump tolerance (about pi).
	localparam int TWO_PI_Q13 = 51472;
	localparam logic [TOL_W-1:0] TOL_RESET = 15'd25736;

	// Largest positive phase, the reset value of the running minimum.
	localparam logic signed [PHASE_W-1:0] PHASE_MAX = 16'sh7FFF;

	typedef logic signed [PHASE_W-1:0] phase_t;
	typedef logic signed [OUT_W-1:0]   unwrapped_t;
	typedef logic [TOL_W-1:0]          tol_t;

endpackage

// ===== rtl/pu_ram.sv =====
module pu_ram import pu_pkg::*; #(
	parameter int WIDTH = PHASE_W,
	parameter int DEPTH = MAX_SAMPLES_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/phase_unwrap_top.sv =====
// Block phase unwrapper. Wrapped phase samples (signed Q2.13 radians) are taken on
// the slave stream, one per cycle, and written into a sample RAM of MAX_SAMPLES
// entries while the smallest sample of the run is tracked. The sample carrying
// tlast closes the run: s_tready then drops and every stored sample is read back
// in order, reduced into [min, min + 2pi), differenced against the previous
// reduced sample and corrected by a running multiple of 2pi whenever the step
// exceeds jump_tolerance. Each result is a signed Q9.13 angle on m_tdata, with
// tlast on the final result of the run and tuser set on every result of a run
// that overflowed the RAM (excess samples are dropped). Each result takes a RAM
// read step and then a compute step, and the compute step waits while the output
// register holds a result that m_tready has not yet taken; the input stays blocked
// until the final result of the run is loaded. The RAM needs no clearing pass after
// reset. The tolerance register is written through the cfg channel, which is always
// ready, and should only be written while no run is being emitted.
module phase_unwrap_top import pu_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// Sample stream. s_tdata: [15:0] phase_in.
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,
	input  logic             s_tlast,
	// Result stream. m_tdata: [22:0] unwrapped_phase, [23] zero.
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,
	output logic             m_tlast,
	// m_tuser: [0] truncated.
	output logic             m_tuser,
	// Tolerance register write channel. cfg_data: [14:0] jump_tolerance.
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [TOL_W-1:0] cfg_data
);

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int RW = PHASE_W + 2;
	localparam int DW = RW + 1;
	localparam logic signed [RW-1:0]    TWO_PI_R = RW'(TWO_PI_Q13);
	localparam logic signed [OUT_W-1:0] TWO_PI_C = OUT_W'(TWO_PI_Q13);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;

	logic [1:0]              state_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           idx_q;
	phase_t                  min_q;
	logic                    ovf_q;
	tol_t                    tol_q;
	logic signed [RW-1:0]    prev_q;
	logic signed [OUT_W-1:0] corr_q;

	logic                    out_valid_q;
	unwrapped_t              out_phase_q;
	logic                    out_last_q;
	logic                    out_trunc_q;

	logic                    in_acc;
	logic                    store_ok;
	logic                    ram_re;
	logic [PHASE_W-1:0]      ram_rdata;
	phase_t                  sample;
	logic signed [RW-1:0]    d_raw;
	logic signed [RW-1:0]    d_red;
	logic signed [RW-1:0]    red;
	logic signed [DW-1:0]    diff;
	logic signed [DW-1:0]    tol_s;
	logic signed [OUT_W-1:0] corr_base;
	logic signed [OUT_W-1:0] corr_next;
	logic signed [OUT_W:0]   y_sum;
	logic                    last_idx;
	logic                    out_free;
	logic                    out_load;

	assign s_tready  = (state_q == ST_LOAD);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign store_ok  = (count_q < CW'(MAX_SAMPLES));
	assign ram_re    = (state_q == ST_READ);

	pu_ram #(
		.WIDTH(PHASE_W),
		.DEPTH(MAX_SAMPLES)
	) u_ram (
		.clk  (clk),
		.we   (in_acc && store_ok),
		.waddr(count_q[AW-1:0]),
		.wdata(s_tdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// Reduce the sample into [min, min + 2pi) and measure the step from the last one.
	always_comb begin
		sample    = phase_t'(ram_rdata);
		d_raw     = RW'(sample) - RW'(min_q);
		d_red     = (d_raw >= TWO_PI_R) ? (d_raw - TWO_PI_R) : d_raw;
		red       = d_red + RW'(min_q);
		diff      = (idx_q == '0) ? '0 : (DW'(red) - DW'(prev_q));
		tol_s     = DW'({1'b0, tol_q});
		corr_base = (idx_q == '0) ? '0 : corr_q;
		if (diff > tol_s) begin
			corr_next = corr_base - TWO_PI_C;
		end else if (diff < -tol_s) begin
			corr_next = corr_base + TWO_PI_C;
		end else begin
			corr_next = corr_base;
		end
		y_sum = (OUT_W + 1)'(red) + (OUT_W + 1)'(corr_next);
	end

	assign last_idx = (CW'(idx_q) == (count_q - CW'(1)));
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == ST_CALC) && out_free;

	// Run control: loading, read and compute steps, and return to loading.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			idx_q   <= '0;
			min_q   <= PHASE_MAX;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (store_ok) begin
							count_q <= count_q + CW'(1);
							if (phase_t'(s_tdata) < min_q) begin
								min_q <= phase_t'(s_tdata);
							end
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							idx_q   <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (out_free) begin
						if (last_idx) begin
							count_q <= '0;
							min_q   <= PHASE_MAX;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Correction and previous reduced sample carried from one result to the next.
	always_ff @(posedge clk) begin
		if (out_load) begin
			prev_q <= red;
			corr_q <= corr_next;
		end
	end

	// Tolerance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	// Output register; a result waits here until its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_phase_q <= y_sum[OUT_W-1:0];
			out_last_q  <= last_idx;
			out_trunc_q <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_phase_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_trunc_q;

	// The sample that closes a run starts the readout in the next cycle.
	a_last_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> (state_q == ST_READ))
		else $error("run end did not start the readout");

	// A compute cycle always follows a RAM read or a stalled compute cycle.
	a_calc_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |->
		($past(state_q) == ST_READ || $past(state_q) == ST_CALC))
		else $error("compute step without a preceding RAM read");

	// The fill count never passes the store capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SAMPLES))
		else $error("sample count beyond capacity");

	// Loading the final result of a run clears the run state.
	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_idx) |=> (count_q == '0 && !ovf_q && state_q == ST_LOAD))
		else $error("run state not cleared after the final result");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import pu_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 50;
	localparam int LONG_HOLD     = 400;
	localparam int QUIET_ITEMS   = 60;

	typedef enum logic [1:0] {
		STIM_SAMPLE,
		STIM_TOLERANCE,
		STIM_DRAIN
	} stim_kind_e;

	typedef struct {
		stim_kind_e kind;
		phase_t     phase;
		logic       last;
		tol_t       tol;
	} stim_t;

	typedef struct {
		unwrapped_t phase;
		logic       last;
		logic       truncated;
	} unwrap_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	tol_t        cfg_data = TOL_RESET;

	stim_t          sample_queue[$];
	unwrap_result_t expected_phases[$];

	// Mirror of the unwrapper state.
	phase_t sample_mem[MAX_SAMPLES_DEF];
	int     stored_count = 0;
	phase_t run_min = PHASE_MAX;
	bit     run_dropped = 1'b0;
	tol_t   tolerance = TOL_RESET;

	int fail_count = 0;
	int cycle_count = 0;
	int gap_left = 0;
	int settle = 0;
	int stall_left = 0;
	bit long_hold_done = 1'b0;
	bit stim_done = 1'b0;
	bit calm = 1'b0;
	bit quiet_tail = 1'b0;

	phase_unwrap_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Store one accepted sample and, when it closes the run, queue every unwrapped result.
	function automatic void unwrap_sample(phase_t ph, logic lst);
		int d;
		int red;
		int diff;
		int prev;
		int corr;
		unwrap_result_t res;
		if (stored_count < MAX_SAMPLES_DEF) begin
			sample_mem[stored_count] = ph;
			stored_count++;
			if (ph < run_min)
				run_min = ph;
		end else begin
			run_dropped = 1'b1;
		end
		if (!lst)
			return;
		prev = 0;
		corr = 0;
		for (int i = 0; i < stored_count; i++) begin
			// Fold into [min, min + 2pi), then track 2pi jumps between neighbors.
			d = int'(sample_mem[i]) - int'(run_min);
			if (d >= TWO_PI_Q13)
				d -= TWO_PI_Q13;
			red = d + int'(run_min);
			diff = (i == 0) ? 0 : red - prev;
			prev = red;
			if (diff > int'(tolerance))
				corr -= TWO_PI_Q13;
			else if (diff < -int'(tolerance))
				corr += TWO_PI_Q13;
			res.phase = unwrapped_t'(red + corr);
			res.last = (i == stored_count - 1);
			res.truncated = run_dropped;
			expected_phases.push_back(res);
		end
		stored_count = 0;
		run_min = PHASE_MAX;
		run_dropped = 1'b0;
	endfunction

	function automatic void add_sample(int ph, bit lst);
		stim_t s;
		s.kind = STIM_SAMPLE;
		s.phase = phase_t'(ph);
		s.last = lst;
		s.tol = '0;
		sample_queue.push_back(s);
	endfunction

	function automatic void add_control(stim_kind_e kind, int tol);
		stim_t s;
		s.kind = kind;
		s.phase = '0;
		s.last = 1'b0;
		s.tol = tol_t'(tol);
		sample_queue.push_back(s);
	endfunction

	// A smooth run is a wrapped ramp with a random slope; otherwise the samples are raw noise.
	function automatic void add_run(int len, bit smooth);
		int acc;
		int step;
		acc = $urandom_range(0, 51471) - 25736;
		step = $urandom_range(0, 40000) - 20000;
		for (int i = 0; i < len; i++) begin
			if (smooth) begin
				acc += step + $urandom_range(0, 2000) - 1000;
				if (acc >= 25736)
					acc -= TWO_PI_Q13;
				if (acc < -25736)
					acc += TWO_PI_Q13;
				add_sample(acc, i == len - 1);
			end else begin
				add_sample($urandom_range(0, 65535) - 32768, i == len - 1);
			end
		end
	endfunction

	// Stimulus, reset and end of run.
	initial begin
		int random_items;
		int runs;
		int len;
		int pick;
		// Directed part: single-sample runs, range extremes, both jump directions.
		add_sample(-32768, 1'b1);
		add_sample(32767, 1'b1);
		add_sample(0, 1'b0);
		add_sample(32767, 1'b0);
		add_sample(-32768, 1'b0);
		add_sample(25000, 1'b0);
		add_sample(-25000, 1'b0);
		add_sample(100, 1'b1);
		// Zero tolerance turns every nonzero step into a jump.
		add_control(STIM_TOLERANCE, 0);
		add_sample(0, 1'b0);
		add_sample(1, 1'b0);
		add_sample(0, 1'b0);
		add_sample(-1, 1'b0);
		add_sample(1, 1'b1);
		// Widest tolerance; no step in this run exceeds it, so none is a jump.
		add_control(STIM_TOLERANCE, 32767);
		add_sample(-32768, 1'b0);
		add_sample(32767, 1'b0);
		add_sample(0, 1'b0);
		add_sample(16384, 1'b1);
		add_control(STIM_TOLERANCE, int'(TOL_RESET));

		// Full store, last sample dropped, and a long overflowing run.
		add_run(64, 1'b1);
		add_run(65, 1'b1);
		add_run(90, 1'b0);
		add_control(STIM_DRAIN, 0);
		random_items = 219;
		runs = 0;
		while (random_items < 500) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				len = $urandom_range(1, 12);
			else if (pick < 19)
				len = $urandom_range(13, 63);
			else
				len = $urandom_range(64, 80);
			add_run(len, $urandom_range(0, 9) < 7);
			random_items += len;
			runs++;
			if (runs % 6 == 0) begin
				case ($urandom_range(0, 3))
					0: add_control(STIM_TOLERANCE, 0);
					1: add_control(STIM_TOLERANCE, 32767);
					2: add_control(STIM_TOLERANCE, int'(TOL_RESET));
					default: add_control(STIM_TOLERANCE, $urandom_range(0, 32767));
				endcase
			end else if ($urandom_range(0, 9) == 0) begin
				add_control(STIM_DRAIN, 0);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (!(stim_done && expected_phases.size() == 0))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_phases.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Sample and register driver.
	always @(posedge clk) begin
		stim_t head;
		logic  next_valid;
		if (arst_n) begin
			next_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				unwrap_sample(phase_t'(s_tdata), s_tlast);
				next_valid = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				tolerance = cfg_data;
				cfg_valid <= 1'b0;
			end
			quiet_tail <= (sample_queue.size() < QUIET_ITEMS);
			if (!next_valid && !cfg_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (sample_queue.size() == 0) begin
					stim_done = 1'b1;
				end else begin
					head = sample_queue[0];
					if (head.kind == STIM_SAMPLE) begin
						if (!quiet_tail && !calm && $urandom_range(0, 4) == 0) begin
							gap_left = $urandom_range(0, 10);
						end else begin
							s_tdata <= head.phase;
							s_tlast <= head.last;
							next_valid = 1'b1;
							if (head.last)
								calm = ($urandom_range(0, 3) == 0);
							void'(sample_queue.pop_front());
						end
					end else if (expected_phases.size() != 0) begin
						// Hold off until every pending result has come back.
						settle = 0;
					end else if (settle < SETTLE_CYCLES) begin
						settle++;
					end else begin
						settle = 0;
						void'(sample_queue.pop_front());
						if (head.kind == STIM_TOLERANCE) begin
							cfg_data <= head.tol;
							cfg_valid <= 1'b1;
						end
					end
				end
			end
			s_tvalid <= next_valid;
		end
	end

	// Result ready with random stalls and one long hold-off once a large run is queued.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && expected_phases.size() >= 40) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet_tail && !calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 10);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Result monitor: each transaction is checked against the oldest expected result.
	always @(posedge clk) begin
		unwrap_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_phases.size() == 0) begin
				$error("unexpected result: unwrapped_phase %0d", $signed(m_tdata[22:0]));
				fail_count++;
			end else begin
				exp_res = expected_phases.pop_front();
				if (unwrapped_t'(m_tdata[22:0]) !== exp_res.phase) begin
					$error("unwrapped_phase: expected %0d, actual %0d", exp_res.phase,
						$signed(m_tdata[22:0]));
					fail_count++;
				end
				if (m_tlast !== exp_res.last) begin
					$error("last_out: expected %0b, actual %0b", exp_res.last, m_tlast);
					fail_count++;
				end
				if (m_tuser !== exp_res.truncated) begin
					$error("truncated: expected %0b, actual %0b", exp_res.truncated, m_tuser);
					fail_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

// ===== phase_unwrap_top.f =====
rtl/pu_pkg.sv
rtl/pu_ram.sv
rtl/phase_unwrap_top.sv
test/tb_top.sv
